[rtl/stw_pkg.sv]
// Shared types, constants and saturation helpers for the segment timeline walker.
// No dependencies; imported by every module of the block.
package stw_pkg;

   localparam int MAX_SEGMENTS_DEF  = 64;
   localparam int DURATION_BITS_DEF = 24;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int TIME_W      = 31;
   localparam int TC_W        = 32;
   localparam int WIDE_W      = 35;
   localparam int COUNT_W     = 7;
   localparam int OPCODE_W    = 3;
   localparam int SEG_OUT_W   = 6;
   localparam int WIDX_W      = 6;
   localparam int WDUR_W      = 24;
   localparam int REQ_TDATA_W = 64;

   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam logic [TIME_W-1:0]      TIME_MAX   = '1;
   localparam wide_type               TIME_MAX_W = 35'sh0_7FFF_FFFF;
   localparam wide_type               TC_MAX_W   = 35'sh0_7FFF_FFFF;
   localparam wide_type               TC_MIN_W   = 35'sh7_8000_0000;
   localparam logic signed [TC_W-1:0] TC_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [TC_W-1:0] TC_MIN     = 32'sh8000_0000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK      = 3'd0,
      OP_START     = 3'd1,
      OP_PAUSE     = 3'd2,
      OP_DIRECTION = 3'd3,
      OP_WRITE     = 3'd4
   } opcode_type;

   typedef struct packed {
      logic endstop;
      logic paused;
      logic walking;
      logic loop_en;
      logic forward;
   } flags_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_ADD,
      ST_CMP,
      ST_SPAN,
      ST_LOAD,
      ST_DIR2,
      ST_SUM_RD,
      ST_SUM_ADD,
      ST_PROG,
      ST_DIVP,
      ST_OUT
   } state_type;

   function automatic logic [TIME_W-1:0] sat_time(input wide_type v);
      if (v < 0) begin
         return '0;
      end else if (v > TIME_MAX_W) begin
         return TIME_MAX;
      end else begin
         return v[TIME_W-1:0];
      end
   endfunction

   function automatic logic signed [TC_W-1:0] sat_count(input wide_type v);
      if (v < TC_MIN_W) begin
         return TC_MIN;
      end else if (v > TC_MAX_W) begin
         return TC_MAX;
      end else begin
         return v[TC_W-1:0];
      end
   endfunction

endpackage

[rtl/stw_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Shared for the tick modulo and the progress fraction. Uses stw_pkg.
module stw_divider #(
   parameter int DIV_W = 47,
   parameter int DEN_W = 31
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIV_W-1:0]          dividend,
   input  logic [DEN_W-1:0]          divisor,
   output stw_pkg::div_sts_type      status,
   output logic [DIV_W-1:0]          quotient,
   output logic [DEN_W-1:0]          remainder
);
   import stw_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

[rtl/segment_timeline_walker.sv]
// Segment timeline walker: sequencer, duration table and time state.
// Depends on stw_pkg and stw_divider.
//
// One item at a time. A tick runs the shared restoring divider (DIV_W = 31 + FRACTION_BITS)
// for the modulo by the route total, then passes the CMP, SPAN and LOAD states for every
// segment boundary it crosses (at most 2*MAX_SEGMENTS+2), then uses the same divider for
// the progress fraction. Start, pause and direction items also end in the progress step.
// A duration write and a segment_count write re-sum the table, one read and one add per
// active segment, through the single table read port. The result sits in an output
// register; a new item is taken while it waits, and a finished item waits for the result
// slot to free.
module segment_timeline_walker #(
   parameter int MAX_SEGMENTS  = stw_pkg::MAX_SEGMENTS_DEF,
   parameter int DURATION_BITS = stw_pkg::DURATION_BITS_DEF,
   parameter int FRACTION_BITS = stw_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // delta_time, loop_flag, forward_flag, pause_flag, write_index, write_duration
   input  logic [stw_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic [stw_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // current_segment, progress, moving_forward, walking, paused, stopped_at_end
   output logic [((FRACTION_BITS + 11 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stw_pkg::COUNT_W-1:0]       csr_data
);
   import stw_pkg::*;

   localparam int SEG_W   = $clog2(MAX_SEGMENTS);
   localparam int N_W     = $clog2(MAX_SEGMENTS + 1);
   localparam int LIMIT   = 2 * MAX_SEGMENTS + 2;
   localparam int ITER_W  = $clog2(LIMIT + 1);
   localparam int PROG_W  = FRACTION_BITS + 1;
   localparam int DIV_W   = TIME_W + FRACTION_BITS;
   localparam int RSP_W   = ((FRACTION_BITS + 11 + 7) / 8) * 8;
   localparam logic [PROG_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   state_type state_ff, state_in;
   flags_type flags_ff, flags_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [TIME_W-1:0]        total_ff, total_in;
   logic signed [TC_W-1:0]   tc_ff, tc_in;
   logic [TIME_W-1:0]        passed_ff, passed_in;
   logic [SEG_W-1:0]         seg_ff, seg_in;
   logic [DURATION_BITS-1:0] span_ff, span_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   wide_type                 left_ff, left_in;
   logic [TIME_W-1:0]        acc_ff, acc_in;
   logic [N_W-1:0]           idx_ff, idx_in;
   logic                     sum_report_ff, sum_report_in;
   logic [PROG_W-1:0]        prog_ff, prog_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   opcode_type               op_ff, op_in;
   logic [TIME_W-1:0]        delta_ff, delta_in;
   logic                     loop_ff, loop_in;
   logic                     fwd_ff, fwd_in;
   logic                     pause_ff, pause_in;
   logic [WIDX_W-1:0]        widx_ff, widx_in;
   logic [WDUR_W-1:0]        wdur_ff, wdur_in;

   logic [DURATION_BITS-1:0] mem [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0]  valid_ff;
   logic [DURATION_BITS-1:0] rd_ff;
   logic                     rd_valid_ff;
   logic [DURATION_BITS-1:0] rd_val;
   logic [SEG_W-1:0]         rd_addr;
   logic                     mem_we;

   logic                     div_start;
   logic [DIV_W-1:0]         div_dividend;
   logic [TIME_W-1:0]        div_divisor;
   div_sts_type              div_sts;
   logic [DIV_W-1:0]         div_quo;
   logic [TIME_W-1:0]        div_rem;

   logic                     req_acc, csr_acc, rsp_free, active, at_end, step_go, widx_ok;
   logic                     sum_last;
   logic [N_W-1:0]           n_act;
   logic [SEG_W-1:0]         seg_last;
   wide_type                 tc_w, passed_w, total_w, span_w, end_w, num_w, acc_w, rd_w;
   wide_type                 add_w, wrap_w;
   logic [TIME_W-1:0]        sum_new;
   logic [SEG_W-1:0]         seg_rep;
   logic                     dir_rep;

   stw_divider #(
      .DIV_W (DIV_W),
      .DEN_W (TIME_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (count_ff == '0) begin
         n_act = N_W'(1);
      end else if ({25'b0, count_ff} > 32'(MAX_SEGMENTS)) begin
         n_act = N_W'(MAX_SEGMENTS);
      end else begin
         n_act = N_W'(count_ff);
      end
   end

   assign seg_last = SEG_W'(n_act - N_W'(1));
   assign active   = flags_ff.walking || flags_ff.paused;
   assign tc_w     = WIDE_W'(tc_ff);
   assign passed_w = $signed(WIDE_W'(passed_ff));
   assign total_w  = $signed(WIDE_W'(total_ff));
   assign span_w   = $signed(WIDE_W'(span_ff));
   assign acc_w    = $signed(WIDE_W'(acc_ff));
   assign rd_w     = $signed(WIDE_W'(rd_val));
   assign add_w    = (total_ff == '0) ? '0 : $signed(WIDE_W'(div_rem));
   assign end_w    = passed_w + span_w;
   assign num_w    = tc_w - passed_w;
   assign wrap_w   = tc_w - total_w;
   assign sum_new  = sat_time(acc_w + rd_w);
   assign sum_last = (idx_ff == n_act - N_W'(1));
   assign widx_ok  = {26'b0, widx_ff} < 32'(MAX_SEGMENTS);
   assign at_end   = flags_ff.forward ? ((N_W'(seg_ff) + N_W'(1)) >= n_act)
                                      : (seg_ff == '0);
   assign step_go  = (iter_ff < ITER_W'(LIMIT)) && (tc_w >= end_w);
   assign rd_val   = rd_valid_ff ? rd_ff : '0;
   assign rd_addr  = (state_ff == ST_SUM_RD) ? SEG_W'(idx_ff) : seg_ff;
   assign seg_rep  = active ? seg_ff : (flags_ff.endstop ? seg_last : '0);
   assign dir_rep  = active ? flags_ff.forward : 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               state_in = ST_SUM_RD;
            end else if (req_acc) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_TICK: begin
                  if (!flags_ff.walking) state_in = ST_PROG;
                  else if (total_ff == '0) state_in = ST_ADD;
                  else state_in = ST_MOD;
               end
               OP_START:     state_in = ST_SPAN;
               OP_DIRECTION: state_in = active ? ST_DIR2 : ST_PROG;
               OP_WRITE:     state_in = widx_ok ? ST_SUM_RD : ST_PROG;
               default:      state_in = ST_PROG;
            endcase
         end
         ST_MOD: begin
            if (div_sts.done) state_in = ST_ADD;
         end
         ST_ADD: state_in = ST_CMP;
         ST_CMP: begin
            if (step_go && !(at_end && !flags_ff.loop_en)) state_in = ST_SPAN;
            else state_in = ST_PROG;
         end
         ST_SPAN: state_in = ST_LOAD;
         ST_LOAD: state_in = (op_ff == OP_START) ? ST_PROG : ST_CMP;
         ST_DIR2: state_in = ST_PROG;
         ST_SUM_RD: state_in = ST_SUM_ADD;
         ST_SUM_ADD: begin
            if (!sum_last) state_in = ST_SUM_RD;
            else state_in = sum_report_ff ? ST_PROG : ST_IDLE;
         end
         ST_PROG: begin
            if (active && span_ff != '0 && num_w > 0 && num_w < span_w) state_in = ST_DIVP;
            else state_in = ST_OUT;
         end
         ST_DIVP: begin
            if (div_sts.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      flags_in      = flags_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      tc_in         = tc_ff;
      passed_in     = passed_ff;
      seg_in        = seg_ff;
      span_in       = span_ff;
      iter_in       = iter_ff;
      left_in       = left_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      sum_report_in = sum_report_ff;
      prog_in       = prog_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      op_in         = op_ff;
      delta_in      = delta_ff;
      loop_in       = loop_ff;
      fwd_in        = fwd_ff;
      pause_in      = pause_ff;
      widx_in       = widx_ff;
      wdur_in       = wdur_ff;
      mem_we        = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               count_in      = csr_data;
               sum_report_in = 1'b0;
               acc_in        = '0;
               idx_in        = '0;
            end else if (req_acc) begin
               op_in    = opcode_type'(req_tuser);
               delta_in = req_tdata[30:0];
               loop_in  = req_tdata[31];
               fwd_in   = req_tdata[32];
               pause_in = req_tdata[33];
               widx_in  = req_tdata[39:34];
               wdur_in  = req_tdata[63:40];
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_TICK: begin
                  if (flags_ff.walking && total_ff != '0) begin
                     div_start    = 1'b1;
                     div_dividend = DIV_W'(delta_ff);
                     div_divisor  = total_ff;
                  end
               end
               OP_START: begin
                  flags_in.loop_en = loop_ff;
                  flags_in.forward = fwd_ff;
                  flags_in.paused  = 1'b0;
                  flags_in.walking = 1'b1;
                  tc_in            = '0;
                  passed_in        = '0;
                  seg_in           = fwd_ff ? '0 : seg_last;
               end
               OP_PAUSE: begin
                  if (pause_ff) begin
                     if (flags_ff.walking) begin
                        flags_in.paused  = 1'b1;
                        flags_in.walking = 1'b0;
                     end
                  end else if (flags_ff.paused) begin
                     flags_in.paused  = 1'b0;
                     flags_in.walking = 1'b1;
                  end
               end
               OP_DIRECTION: begin
                  if (active) begin
                     passed_in = sat_time(total_w - end_w);
                     left_in   = end_w - tc_w;
                  end
                  flags_in.forward = fwd_ff;
               end
               OP_WRITE: begin
                  if (widx_ok) begin
                     mem_we           = 1'b1;
                     tc_in            = '0;
                     seg_in           = '0;
                     passed_in        = '0;
                     flags_in.endstop = 1'b0;
                     flags_in.walking = 1'b0;
                     flags_in.paused  = 1'b0;
                     sum_report_in    = 1'b1;
                     acc_in           = '0;
                     idx_in           = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ADD: begin
            tc_in   = sat_count(tc_w + add_w);
            iter_in = '0;
         end
         ST_CMP: begin
            if (step_go) begin
               iter_in = iter_ff + ITER_W'(1);
               if (at_end) begin
                  if (flags_ff.loop_en) begin
                     seg_in    = flags_ff.forward ? '0 : seg_last;
                     passed_in = '0;
                     tc_in     = (wrap_w < 0) ? '0 : wrap_w[TC_W-1:0];
                  end else begin
                     tc_in            = sat_count(end_w);
                     flags_in.walking = 1'b0;
                     flags_in.endstop = flags_ff.forward;
                  end
               end else begin
                  seg_in    = flags_ff.forward ? seg_ff + SEG_W'(1) : seg_ff - SEG_W'(1);
                  passed_in = sat_time(end_w);
               end
            end
         end
         ST_LOAD: span_in = rd_val;
         ST_DIR2: tc_in = sat_count(passed_w + left_ff);
         ST_SUM_ADD: begin
            if (sum_last) begin
               total_in = sum_new;
            end else begin
               acc_in = sum_new;
               idx_in = idx_ff + N_W'(1);
            end
         end
         ST_PROG: begin
            if (active) begin
               if (span_ff == '0 || num_w >= span_w) begin
                  prog_in = ONE;
               end else if (num_w <= 0) begin
                  prog_in = '0;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = DIV_W'({num_w[DURATION_BITS-1:0], {FRACTION_BITS{1'b0}}});
                  div_divisor  = TIME_W'(span_ff);
               end
            end else begin
               prog_in = flags_ff.endstop ? ONE : '0;
            end
         end
         ST_DIVP: begin
            if (div_sts.done) prog_in = {1'b0, div_quo[FRACTION_BITS-1:0]};
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({flags_ff.endstop, flags_ff.paused, flags_ff.walking,
                                      dir_rep, prog_ff, SEG_OUT_W'(seg_rep)});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '{endstop: 1'b0, paused: 1'b0, walking: 1'b0,
                           loop_en: 1'b1, forward: 1'b1};
         count_ff     <= COUNT_W'(1);
         total_ff     <= '0;
         tc_ff        <= '0;
         passed_ff    <= '0;
         seg_ff       <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         tc_ff        <= tc_in;
         passed_ff    <= passed_in;
         seg_ff       <= seg_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iter_ff       <= iter_in;
      left_ff       <= left_in;
      acc_ff        <= acc_in;
      idx_ff        <= idx_in;
      sum_report_ff <= sum_report_in;
      prog_ff       <= prog_in;
      rsp_data_ff   <= rsp_data_in;
      op_ff         <= op_in;
      delta_ff      <= delta_in;
      loop_ff       <= loop_in;
      fwd_ff        <= fwd_in;
      pause_ff      <= pause_in;
      widx_ff       <= widx_in;
      wdur_ff       <= wdur_in;
   end

   // duration table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[SEG_W'(widx_ff)] <= DURATION_BITS'(wdur_ff);
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) valid_ff[SEG_W'(widx_ff)] <= 1'b1;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && csr_valid && csr_ready))
      else $error("item and csr write taken together");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff.walking && flags_ff.paused))
      else $error("walking and paused both set");

   a_prog_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (prog_ff <= ONE))
      else $error("progress above one");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

endmodule

[bench/segment_timeline_walker_tb.sv]
// Self-checking bench for segment_timeline_walker: random and directed items, predicted
// results compared field by field. Depends on stw_pkg and the walker RTL.
`timescale 1ns / 100ps

module segment_timeline_walker_tb;
   import stw_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int  NSEG      = MAX_SEGMENTS_DEF;
   localparam int  WALK_CAP  = 2 * NSEG + 2;
   localparam longint ONE_Q  = 64'd1 << FRACTION_BITS_DEF;
   localparam int  IDLE_LIMIT = 4000;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [30:0]         delta;
      logic                loop_f;
      logic                fwd_f;
      logic                pause_f;
      logic [5:0]          widx;
      logic [23:0]         wdur;
   } walk_cmd_type;

   typedef struct packed {
      logic        endstop;
      logic        paused;
      logic        walking;
      logic        fwd;
      logic [16:0] prog;
      logic [5:0]  seg;
   } walk_rsp_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [6:0]  csr_data;

   segment_timeline_walker u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   walk_cmd_type cmd_queue[$];
   walk_rsp_type rsp_expected[$];
   int errors = 0, n_items = 0, n_results = 0, n_csr = 0;

   // walker state mirror
   logic [23:0] dur_tab[NSEG];
   longint total_ms, tcount, passed_ms, span_ms;
   int     seg_now, seg_cnt;
   bit     f_fwd, f_loop, f_walk, f_pause, f_end;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int used_segments();
      return seg_cnt < 1 ? 1 : (seg_cnt > NSEG ? NSEG : seg_cnt);
   endfunction

   function automatic longint clamp_time(longint v);
      return v < 0 ? 0 : (v > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : v);
   endfunction

   function automatic longint clamp_count(longint v);
      return v < -64'sh8000_0000 ? -64'sh8000_0000 :
             (v > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : v);
   endfunction

   function automatic longint seg_length(int s);
      return s < NSEG ? longint'(dur_tab[s]) : 0;
   endfunction

   function automatic void sum_route();
      longint acc;
      acc = 0;
      for (int i = 0; i < used_segments(); i++) begin
         acc += dur_tab[i];
         if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
      end
      total_ms = acc;
   endfunction

   function automatic void reset_walker();
      foreach (dur_tab[i]) dur_tab[i] = '0;
      total_ms = 0; tcount = 0; passed_ms = 0; seg_now = 0; span_ms = 0;
      f_fwd = 1; f_loop = 1; f_walk = 0; f_pause = 0; f_end = 0; seg_cnt = 1;
   endfunction

   function automatic void advance_time(longint d_in);
      int n, steps;
      longint d;
      bit at_end;
      n = used_segments();
      steps = 0;
      if (!f_walk) return;
      d = total_ms > 0 ? d_in % total_ms : 0;
      tcount = clamp_count(tcount + d);
      while (steps < WALK_CAP && tcount >= passed_ms + span_ms) begin
         at_end = f_fwd ? (seg_now + 1 >= n) : (seg_now == 0);
         steps++;
         if (at_end) begin
            if (f_loop) begin
               seg_now = f_fwd ? 0 : n - 1;
               passed_ms = 0;
               tcount -= total_ms;
               if (tcount < 0) tcount = 0;
            end else begin
               tcount = clamp_count(passed_ms + span_ms);
               f_walk = 0;
               f_end = f_fwd;
               break;
            end
         end else begin
            seg_now = f_fwd ? seg_now + 1 : seg_now - 1;
            passed_ms = clamp_time(passed_ms + span_ms);
         end
         span_ms = seg_length(seg_now);
      end
   endfunction

   function automatic walk_rsp_type walk_step(walk_cmd_type c);
      walk_rsp_type r;
      longint num, stop_at, left;
      int n;
      n = used_segments();
      case (c.op)
         OP_TICK: advance_time(longint'(c.delta));
         OP_START: begin
            f_loop = c.loop_f; f_fwd = c.fwd_f; f_pause = 0; f_walk = 1;
            tcount = 0; passed_ms = 0;
            seg_now = c.fwd_f ? 0 : n - 1;
            span_ms = seg_length(seg_now);
         end
         OP_PAUSE: begin
            if (c.pause_f) begin
               if (f_walk) begin
                  f_pause = 1; f_walk = 0;
               end
            end else if (f_pause) begin
               f_pause = 0; f_walk = 1;
            end
         end
         OP_DIRECTION: begin
            if (f_walk || f_pause) begin
               stop_at = passed_ms + span_ms;
               left = stop_at - tcount;
               passed_ms = clamp_time(total_ms - stop_at);
               tcount = clamp_count(passed_ms + left);
            end
            f_fwd = c.fwd_f;
         end
         OP_WRITE: begin
            dur_tab[c.widx] = c.wdur;
            tcount = 0; seg_now = 0; passed_ms = 0;
            f_end = 0; f_walk = 0; f_pause = 0;
            sum_route();
         end
         default: ;
      endcase
      if (f_walk || f_pause) begin
         num = tcount - passed_ms;
         r.seg = seg_now[5:0];
         r.fwd = f_fwd;
         if (span_ms <= 0 || num >= span_ms) r.prog = 17'(ONE_Q);
         else if (num <= 0) r.prog = '0;
         else r.prog = 17'((num << FRACTION_BITS_DEF) / span_ms);
      end else begin
         r.fwd = 1;
         r.seg = f_end ? 6'(n - 1) : '0;
         r.prog = f_end ? 17'(ONE_Q) : '0;
      end
      r.walking = f_walk;
      r.paused = f_pause;
      r.endstop = f_end;
      return r;
   endfunction

   // ---------------- stimulus helpers
   function automatic void push_cmd(int unsigned op, int unsigned d, int unsigned lp,
                                    int unsigned fw, int unsigned pz, int unsigned wi,
                                    int unsigned wd);
      walk_cmd_type c;
      c.op = OPCODE_W'(op); c.delta = 31'(d); c.loop_f = lp[0]; c.fwd_f = fw[0];
      c.pause_f = pz[0]; c.widx = 6'(wi); c.wdur = 24'(wd);
      cmd_queue.push_back(c);
   endfunction

   function automatic void push_noise();
      push_cmd($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
   endfunction

   function automatic int unsigned pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 15) return $urandom & 32'h00FF_FFFF;
      return $urandom_range(1, 600);
   endfunction

   function automatic int unsigned pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 0;
      if (r < 15) return $urandom & 32'h7FFF_FFFF;
      return $urandom_range(1, 900);
   endfunction

   // one route build, start and a burst of walking
   function automatic void push_route(int nseg);
      int nt;
      for (int i = 0; i < nseg; i++)
         push_cmd(OP_WRITE, $urandom, $urandom, $urandom, $urandom, i, pick_duration());
      push_cmd(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      nt = $urandom_range(4, 14);
      for (int i = 0; i < nt; i++) begin
         case ($urandom_range(0, 9))
            0: push_cmd(OP_PAUSE, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
            1: push_cmd(OP_DIRECTION, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
            2: push_noise();
            default: push_cmd(OP_TICK, pick_delta(), $urandom, $urandom, $urandom,
                              $urandom, $urandom);
         endcase
      end
   endfunction

   function automatic logic [63:0] pack_cmd(walk_cmd_type c);
      return {c.wdur, c.widx, c.pause_f, c.fwd_f, c.loop_f, c.delta};
   endfunction

   // ---------------- sender
   bit req_took;
   int send_gap = 0;
   bit calm = 0;

   function automatic int draw_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(negedge clock) begin
      walk_cmd_type c;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_took) begin
         if (send_gap > 0 || cmd_queue.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_tvalid <= 0;
         end else begin
            c = cmd_queue.pop_front();
            req_tdata <= pack_cmd(c);
            req_tuser <= c.op;
            req_tvalid <= 1;
            send_gap = draw_gap();
            if ($urandom_range(0, 99) == 0) calm = !calm;
         end
      end
   end

   // ---------------- receiver
   int hold_cnt = 0, stall_cnt = 0;
   bit long_hold_done = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (!long_hold_done && n_results >= 150) begin
         long_hold_done = 1;
         hold_cnt = 400;
         rsp_tready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 0;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_tready <= 0;
      end else begin
         stall_cnt = calm ? 0 : draw_gap();
         rsp_tready <= 1;
      end
   end

   // ---------------- monitor and predictor
   int idle_cycles = 0;

   always @(posedge clock) begin
      walk_cmd_type c;
      walk_rsp_type e, a;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            c.op = req_tuser; c.delta = req_tdata[30:0]; c.loop_f = req_tdata[31];
            c.fwd_f = req_tdata[32]; c.pause_f = req_tdata[33];
            c.widx = req_tdata[39:34]; c.wdur = req_tdata[63:40];
            rsp_expected.push_back(walk_step(c));
            n_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            a = walk_rsp_type'(rsp_tdata[26:0]);
            n_results++;
            if (rsp_expected.size() == 0) begin
               $error("result with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               e = rsp_expected.pop_front();
               if (a.seg !== e.seg) begin
                  $error("current_segment exp %0d got %0d", e.seg, a.seg); errors++;
               end
               if (a.prog !== e.prog) begin
                  $error("progress exp %0d got %0d", e.prog, a.prog); errors++;
               end
               if (a.fwd !== e.fwd) begin
                  $error("moving_forward exp %0d got %0d", e.fwd, a.fwd); errors++;
               end
               if (a.walking !== e.walking) begin
                  $error("walking exp %0d got %0d", e.walking, a.walking); errors++;
               end
               if (a.paused !== e.paused) begin
                  $error("paused exp %0d got %0d", e.paused, a.paused); errors++;
               end
               if (a.endstop !== e.endstop) begin
                  $error("stopped_at_end exp %0d got %0d", e.endstop, a.endstop); errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) ||
             (cmd_queue.size() == 0 && rsp_expected.size() == 0 && !csr_valid))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("segment_timeline_walker verification failed");
            $finish;
         end
      end
   end

   // ---------------- sequencing
   task automatic drain();
      while (cmd_queue.size() != 0 || rsp_expected.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      seg_cnt = int'(v);
      sum_route();
      n_csr++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   logic [6:0] count_plan[8] = '{7'd1, 7'd64, 7'd4, 7'd0, 7'd127, 7'd3, 7'd20, 7'd2};

   initial begin
      int nroute;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 0; csr_valid = 0; csr_data = '0;
      reset_walker();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: idle report, extremes, every opcode, unused codes
      push_cmd(OP_TICK, 31'h7FFF_FFFF, 0, 0, 0, 0, 0);
      push_cmd(OP_START, 0, 1, 1, 0, 0, 0);
      push_cmd(OP_TICK, 31'd5, 0, 0, 0, 0, 0);
      push_cmd(OP_WRITE, 0, 0, 0, 0, 6'd0, 24'hFF_FFFF);
      push_cmd(OP_WRITE, 0, 0, 0, 0, 6'd63, 24'hFF_FFFF);
      push_cmd(OP_START, 0, 0, 1, 0, 0, 0);
      push_cmd(OP_TICK, 31'h7FFF_FFFF, 0, 0, 0, 0, 0);
      push_cmd(OP_TICK, 31'd8_000_000, 0, 0, 0, 0, 0);
      push_cmd(OP_PAUSE, 0, 0, 0, 1, 0, 0);
      push_cmd(OP_PAUSE, 0, 0, 0, 1, 0, 0);
      push_cmd(OP_DIRECTION, 0, 0, 0, 0, 0, 0);
      push_cmd(OP_PAUSE, 0, 0, 0, 0, 0, 0);
      push_cmd(OP_TICK, 31'd100, 0, 0, 0, 0, 0);
      push_cmd(OP_START, 0, 0, 0, 0, 0, 0);
      push_cmd(OP_TICK, 31'h7FFF_FFFE, 0, 0, 0, 0, 0);
      push_cmd(OP_UNUSED_LO, 31'h7FFF_FFFF, 1, 1, 1, 6'h3F, 24'hFF_FFFF);
      push_cmd(OP_UNUSED_HI, 0, 0, 0, 0, 0, 0);
      push_cmd(OP_WRITE, 0, 0, 0, 0, 6'd0, 24'd0);
      push_cmd(OP_START, 0, 1, 1, 0, 0, 0);
      push_cmd(OP_TICK, 31'd1, 0, 0, 0, 0, 0);
      drain();

      foreach (count_plan[p]) begin
         write_count(count_plan[p]);
         while (cmd_queue.size() < 95) begin
            nroute = (count_plan[p] == 0) ? 1 : $urandom_range(1, count_plan[p] > 8 ? 8 :
                                                              count_plan[p]);
            if ($urandom_range(0, 4) == 0) nroute = $urandom_range(1, 64);
            if ($urandom_range(0, 7) == 0) push_noise();
            else push_route(nroute);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d items, %0d results, %0d segment_count writes", n_items,
               n_results, n_csr);
      $display("routes walked forward and backward, looping and stopping, with stalls");
      if (errors == 0 && rsp_expected.size() == 0)
         $display("segment_timeline_walker verification clean");
      else
         $display("segment_timeline_walker verification failed");
      $finish;
   end

endmodule

[segment_timeline_walker.f]
rtl/stw_pkg.sv
rtl/stw_divider.sv
rtl/segment_timeline_walker.sv
bench/segment_timeline_walker_tb.sv
